[src/khssr_pkg.sv]
// ----------------------------------------------------------------------------
// khssr_pkg
// shared types and constants of the key hash slot shard router
// ----------------------------------------------------------------------------
package khssr_pkg;

  // defaults of the top level parameters
  localparam int SLOT_COUNT_DEF = 16384;
  localparam int SHARD_MAX_DEF  = 16;

  // fixed field widths
  localparam int KEY_W          = 8;
  localparam int SHARD_W        = 4;
  localparam int SLOT_FIELD_W   = 14;
  localparam int SLOT_IDX_MAX_W = 16;
  localparam int CRC_W          = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // input item kinds
  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_ASSIGN = 1'b1;

  // queued command codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [CRC_W-1:0]          crc;
    logic [SHARD_W-1:0]        requester;
    logic [SLOT_IDX_MAX_W-1:0] lo;
    logic [SLOT_IDX_MAX_W-1:0] hi;
    logic [SHARD_W-1:0]        owner;
  } cmd_t;

endpackage

[src/khssr_ifs.sv]
// ----------------------------------------------------------------------------
// khssr channel interfaces
// valid/ready channels for key items in and routing results out
// ----------------------------------------------------------------------------
interface khssr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  key_byte;
  logic        last_byte;
  logic [3:0]  requester_id;
  logic [13:0] range_low;
  logic [13:0] range_high;
  logic [3:0]  owner_shard;

  modport source (output valid, kind, key_byte, last_byte, requester_id,
                  range_low, range_high, owner_shard, input ready);
  modport sink (input valid, kind, key_byte, last_byte, requester_id,
                range_low, range_high, owner_shard, output ready);
endinterface

interface khssr_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] hash_slot;
  logic [3:0]  target_shard;
  logic        for_requester;

  modport source (output valid, hash_slot, target_shard, for_requester,
                  input ready);
  modport sink (input valid, hash_slot, target_shard, for_requester,
                output ready);
endinterface

[src/key_hash_slot_shard_router_unit.sv]
// ----------------------------------------------------------------------------
// key_hash_slot_shard_router_unit
// routes streamed keys to cluster shards by crc-16 hash slot
// ----------------------------------------------------------------------------
//
//   port       dir  items
//   ---------  ---  ---------------------------------------------------------
//   key_in     in   key bytes (kind 0) or slot range assigns (kind 1)
//   route_out  out  hash slot, owning shard and requester match, one per key
//
// key bytes are taken one per cycle while the command queue has room; only a
// key's last byte and a valid range assign enter the queue.
// a lookup runs through the back end as pop, reciprocal multiply, remainder,
// slot map read and result, plus any wait on route_out.ready.
// a range fill pops its command and then writes one slot at a time through
// the single write port of the slot map.
// reset clears the running crc, the queue and the back end state; the slot
// map is not cleared and must be loaded before keys are looked up.
// a stalled result holds in the back end while the front keeps hashing until the queue is full.
//
module key_hash_slot_shard_router_unit #(
  parameter int SLOT_COUNT = khssr_pkg::SLOT_COUNT_DEF,
  parameter int SHARD_MAX  = khssr_pkg::SHARD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  khssr_in_if.sink    key_in,
  khssr_out_if.source route_out
);
  import khssr_pkg::*;

  // command queue hookup
  cmd_t push_data;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // front: crc per key byte, range checks, queue push
  khssr_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .SHARD_MAX  (SHARD_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_in),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decouples hashing from slow fills and stalled results
  khssr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // back: slot map owner, fill sweep and lookup pipeline
  khssr_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .route_out (route_out)
  );

endmodule

[src/khssr_front.sv]
// ----------------------------------------------------------------------------
// khssr_front
// accepts items, runs the key crc and queues lookups and range fills
// ----------------------------------------------------------------------------
module khssr_front #(
  parameter int SLOT_COUNT = khssr_pkg::SLOT_COUNT_DEF,
  parameter int SHARD_MAX  = khssr_pkg::SHARD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  khssr_in_if.sink          key_in,
  output logic              push,
  output khssr_pkg::cmd_t   push_data,
  input  logic              full
);
  import khssr_pkg::*;

  localparam logic [16:0] SLOT_LAST = 17'(SLOT_COUNT - 1);

  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] crc_upd;
  logic [16:0]      hi_sat;
  logic             owner_ok;
  logic             range_ok;
  logic             accept;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [KEY_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  assign key_in.ready = !full;
  assign accept       = key_in.valid && key_in.ready;

  always_comb begin
    crc_upd  = crc_feed(running_crc, key_in.key_byte);
    owner_ok = 9'(key_in.owner_shard) < 9'(SHARD_MAX);
    hi_sat   = (17'(key_in.range_high) > SLOT_LAST) ? SLOT_LAST : 17'(key_in.range_high);
    range_ok = 17'(key_in.range_low) <= hi_sat;

    if (key_in.kind == KIND_KEY) begin
      push = accept && key_in.last_byte;
    end else begin
      push = accept && owner_ok && range_ok;
    end

    push_data.op        = (key_in.kind == KIND_KEY) ? OP_LOOKUP : OP_FILL;
    push_data.crc       = crc_upd;
    push_data.requester = key_in.requester_id;
    push_data.lo        = SLOT_IDX_MAX_W'(key_in.range_low);
    push_data.hi        = hi_sat[SLOT_IDX_MAX_W-1:0];
    push_data.owner     = key_in.owner_shard;
  end

  // crc restarts after the last byte of each key; range assigns leave it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (accept && key_in.kind == KIND_KEY) begin
      running_crc <= key_in.last_byte ? '0 : crc_upd;
    end
  end

  a_assign_keeps_crc: assert property (@(posedge clk) disable iff (rst)
    (accept && key_in.kind == KIND_ASSIGN) |=> $stable(running_crc))
    else $error("range assign changed the running crc");

endmodule

[src/khssr_queue.sv]
// ----------------------------------------------------------------------------
// khssr_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module khssr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  khssr_pkg::cmd_t push_data,
  input  logic            pop,
  output khssr_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);
  import khssr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

[src/khssr_back.sv]
// ----------------------------------------------------------------------------
// khssr_back
// carries out queued commands: slot map fills and slot lookups
// ----------------------------------------------------------------------------
module khssr_back #(
  parameter int SLOT_COUNT = khssr_pkg::SLOT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  khssr_pkg::cmd_t head,
  input  logic            empty,
  output logic            pop,
  khssr_out_if.source     route_out
);
  import khssr_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  // crc mod SLOT_COUNT via reciprocal: exact for any 16-bit crc
  localparam longint unsigned RECIP = ((64'd1 << 32) + SLOT_COUNT - 1) / SLOT_COUNT;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = CRC_W + RECIP_W;
  localparam int QUO_W   = PROD_W - 32;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [SHARD_W-1:0] slot_map [SLOT_COUNT];

  logic [2:0]          state;
  logic [SLOT_W-1:0]   cur;
  logic [SLOT_W-1:0]   fill_hi;
  logic [SHARD_W-1:0]  owner;
  logic [CRC_W-1:0]    crc;
  logic [SHARD_W-1:0]  requester;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W-1:0]   slot;
  logic [SHARD_W-1:0]  rd_data;
  logic [31:0]         rem_full;
  logic [QUO_W-1:0]    quo;
  logic [15:0]         slot_wide;

  assign pop      = (state == ST_IDLE) && !empty;
  assign quo      = prod[PROD_W-1:32];
  assign rem_full = 32'(crc) - 32'(quo) * 32'(SLOT_COUNT);
  assign slot_wide = 16'(slot);

  assign route_out.valid         = state == ST_OUT;
  assign route_out.hash_slot     = slot_wide[SLOT_FIELD_W-1:0];
  assign route_out.target_shard  = rd_data;
  assign route_out.for_requester = rd_data == requester;

  // slot map: one write port for fills, one registered read for lookups
  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      slot_map[cur] <= owner;
    end
    rd_data <= slot_map[slot];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= head.lo[SLOT_W-1:0];
      fill_hi   <= head.hi[SLOT_W-1:0];
      owner     <= head.owner;
      crc       <= head.crc;
      requester <= head.requester;
    end else if (state == ST_FILL) begin
      cur <= cur + 1'b1;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(crc) * PROD_W'(RECIP);
    end
    if (state == ST_SUB) begin
      slot <= rem_full[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= (head.op == OP_FILL) ? ST_FILL : ST_MUL;
          end
        end
        ST_FILL: begin
          if (cur == fill_hi) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL:  state <= ST_SUB;
        ST_SUB:  state <= ST_READ;
        ST_READ: state <= ST_OUT;
        ST_OUT: begin
          if (route_out.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cur <= fill_hi))
    else $error("fill pointer ran past the range end");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (route_out.valid && !route_out.ready) |=>
      (route_out.valid && $stable(slot) && $stable(requester)))
    else $error("result changed while waiting");

endmodule
